// ===== hw/rtl/com_pkg.sv =====
// Package: shared constants, types and state codes for the centre of mass block.
package com_pkg;

  localparam int MAX_ATOMS    = 64;
  localparam int IDX_W        = $clog2(MAX_ATOMS);
  localparam int CNT_W        = $clog2(MAX_ATOMS + 1);
  localparam int ATOM_IDX_W   = 6;
  localparam int MASS_W       = 16;
  localparam int COORD_W      = 32;
  localparam int MSUM_W       = 22;
  localparam int WSUM_W       = 60;
  localparam int PROD_W       = COORD_W + MASS_W + 1;
  localparam int NUM_W        = WSUM_W + 1;
  localparam int DEN_W        = MSUM_W + 1;
  localparam int REM_W        = DEN_W + 1;
  localparam int DIV_STEPS    = NUM_W;
  localparam int DCNT_W       = $clog2(DIV_STEPS);
  localparam int SCALE_Q16    = 34680;
  localparam logic [MSUM_W-1:0] MASS_MAX = {MSUM_W{1'b1}};
  localparam int IN_DATA_W    = 112;
  localparam int OUT_DATA_W   = 224;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MAC,
    ST_ACC,
    ST_CHK,
    ST_DIV,
    ST_RD,
    ST_LD,
    ST_OUT
  } com_state_e;

  typedef struct packed {
    logic capture;
    logic scale;
    logic mac;
    logic acc;
    logic div_init;
    logic div_step;
    logic rd;
    logic ld;
    logic next;
    logic clear;
  } com_cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_zero;
    logic div_done;
    logic emit_last;
  } com_sts_t;

endpackage

// ===== hw/rtl/centre_of_mass_recenter_top.sv =====
// Top level: stream ports, configuration register, controller and datapath.
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid/tready          | tdata: mass, x, y, z; tlast: final atom
//  m_axis    | out | tvalid/tready          | tdata: index, rel, mass, centre; tlast; tuser
//  apb       | in  | psel/penable/pready    | scale_enable at addresses 0-3 (paddr[2] low)
// Each atom is loaded in steps: capture, scale, multiply, accumulate, check.
// A final atom then runs the bit-serial centre division, and each word is emitted
// through read, load and output steps, waiting out any stall on m_axis_tready.
// Reset clears counters, sums and the state machine; the coordinate store is not cleared.
// s_axis_tready is low from capture to check, or until full emit after a final atom.
module centre_of_mass_recenter_top import com_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // atom_mass, pos_x, pos_y, pos_z
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // atom_index, rel_x, rel_y, rel_z, mass_total, centre_x, centre_y, centre_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic [0:0]            m_axis_tuser,   // zero_mass
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                      scale_q;
  com_cmd_t                  cmd;
  com_sts_t                  sts;
  logic signed [COORD_W-1:0] pos [3];
  logic signed [COORD_W-1:0] rel [3];
  logic signed [COORD_W-1:0] cen [3];
  logic [ATOM_IDX_W-1:0]     idx;
  logic [MSUM_W-1:0]         mass_total;
  logic                      zero;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, scale_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      scale_q <= pwdata[0];
    end
  end

  assign pos[0] = s_axis_tdata[47:16];
  assign pos[1] = s_axis_tdata[79:48];
  assign pos[2] = s_axis_tdata[111:80];

  com_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  com_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .scale_en_i   (scale_q),
    .mass_i       (s_axis_tdata[15:0]),
    .pos_i        (pos),
    .last_i       (s_axis_tlast),
    .sts_o        (sts),
    .idx_o        (idx),
    .rel_o        (rel),
    .mass_total_o (mass_total),
    .cen_o        (cen),
    .run_end_o    (m_axis_tlast),
    .zero_o       (zero)
  );

  assign m_axis_tdata = {4'b0, cen[2], cen[1], cen[0], mass_total,
                         rel[2], rel[1], rel[0], idx};
  assign m_axis_tuser = zero;

`ifndef SYNTHESIS
  a_zero_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && zero) |-> (cen[0] == '0 && cen[1] == '0 && cen[2] == '0))
    else $error("zero mass with nonzero centre");
  a_zero_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && zero) |-> (mass_total == '0))
    else $error("zero mass flag with mass");
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(scale_q))
    else $error("scale register changed without write");
`endif

endmodule

// ===== hw/rtl/com_ctrl.sv =====
// Controller: sequences load, accumulate, divide and emit phases.
module com_ctrl import com_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  com_sts_t sts_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output com_cmd_t cmd_o
);

  com_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_MAC;
      ST_MAC:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_CHK;
      ST_CHK: begin
        if (!sts_i.last || sts_i.cnt_zero) state_d = ST_IDLE;
        else                               state_d = ST_DIV;
      end
      ST_DIV:   if (sts_i.div_done) state_d = ST_RD;
      ST_RD:    state_d = ST_LD;
      ST_LD:    state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = sts_i.emit_last ? ST_IDLE : ST_RD;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_MAC:   cmd_o.mac   = 1'b1;
      ST_ACC:   cmd_o.acc   = 1'b1;
      ST_CHK: begin
        cmd_o.div_init = sts_i.last && !sts_i.cnt_zero;
        cmd_o.clear    = sts_i.last && sts_i.cnt_zero;
      end
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_RD:    cmd_o.rd = 1'b1;
      ST_LD:    cmd_o.ld = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.next  = out_ready_i;
        cmd_o.clear = out_ready_i && sts_i.emit_last;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && state_d == ST_RD) |-> sts_i.div_done)
    else $error("division left early");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("load and emit overlap");
  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_LD) ##1 (state_q == ST_OUT))
    else $error("emit sequence broken");
`endif

endmodule

// ===== hw/rtl/com_dp.sv =====
// Datapath: scaling, weighted accumulation, coordinate store, divider and re-centering.
module com_dp import com_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  com_cmd_t                     cmd_i,
  input  logic                         scale_en_i,
  input  logic [MASS_W-1:0]            mass_i,
  input  logic signed [COORD_W-1:0]    pos_i [3],
  input  logic                         last_i,
  output com_sts_t                     sts_o,
  output logic [ATOM_IDX_W-1:0]        idx_o,
  output logic signed [COORD_W-1:0]    rel_o [3],
  output logic [MSUM_W-1:0]            mass_total_o,
  output logic signed [COORD_W-1:0]    cen_o [3],
  output logic                         run_end_o,
  output logic                         zero_o
);

  logic [COORD_W-1:0] mem_x [MAX_ATOMS];
  logic [COORD_W-1:0] mem_y [MAX_ATOMS];
  logic [COORD_W-1:0] mem_z [MAX_ATOMS];

  logic [MASS_W-1:0]         mass_q;
  logic signed [COORD_W-1:0] pin_q [3];
  logic signed [COORD_W-1:0] sc_q [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic                      last_q;
  logic [MSUM_W-1:0]         msum_q;
  logic signed [WSUM_W-1:0]  wsum_q [3];
  logic [CNT_W-1:0]          cnt_q;
  logic [NUM_W-1:0]          num_q [3];
  logic [REM_W-1:0]          rem_q [3];
  logic [NUM_W-1:0]          quo_q [3];
  logic                      neg_q [3];
  logic [DEN_W-1:0]          den_q;
  logic [DCNT_W-1:0]         dcnt_q;
  logic [IDX_W-1:0]          idx_q;
  logic [COORD_W-1:0]        rd_q [3];
  logic signed [COORD_W-1:0] cen_c [3];
  logic                      emit_last;
  logic                      zero_c;
  logic [MSUM_W:0]           msum_add;

  assign zero_c    = (msum_q == '0);
  assign emit_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign msum_add  = {1'b0, msum_q} + (MSUM_W+1)'(mass_q);

  assign sts_o.last      = last_q;
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.div_done  = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
  assign sts_o.emit_last = emit_last;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (zero_c) begin
        cen_c[a] = '0;
      end else if (!neg_q[a]) begin
        cen_c[a] = (quo_q[a][NUM_W-1:COORD_W-1] != '0) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                       : quo_q[a][COORD_W-1:0];
      end else begin
        cen_c[a] = (quo_q[a] > NUM_W'({1'b1, {(COORD_W-1){1'b0}}}))
                 ? {1'b1, {(COORD_W-1){1'b0}}} : -quo_q[a][COORD_W-1:0];
      end
    end
  end

  // input, scale and multiply stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mass_q <= mass_i;
      for (int a = 0; a < 3; a++) pin_q[a] <= pos_i[a];
    end
    if (cmd_i.scale) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(pin_q[a] * $signed({1'b0, MASS_W'(SCALE_Q16)}))
          + PROD_W'(32768);
        sc_q[a] <= scale_en_i ? p[COORD_W+15:16] : pin_q[a];
      end
    end
    if (cmd_i.mac) begin
      for (int a = 0; a < 3; a++) prod_q[a] <= sc_q[a] * $signed({1'b0, mass_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.capture) begin
      last_q <= last_i;
    end
  end

  // accumulators and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msum_q <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
      dcnt_q <= '0;
      for (int a = 0; a < 3; a++) wsum_q[a] <= '0;
    end else if (cmd_i.clear) begin
      msum_q <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
      for (int a = 0; a < 3; a++) wsum_q[a] <= '0;
    end else begin
      if (cmd_i.acc && cnt_q < CNT_W'(MAX_ATOMS)) begin
        msum_q <= msum_add[MSUM_W] ? MASS_MAX : msum_add[MSUM_W-1:0];
        cnt_q  <= cnt_q + CNT_W'(1);
        for (int a = 0; a < 3; a++) wsum_q[a] <= wsum_q[a] + WSUM_W'(prod_q[a]);
      end
      if (cmd_i.div_init) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);
      if (cmd_i.next) idx_q <= idx_q + IDX_W'(1);
    end
  end

  // coordinate store
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && cnt_q < CNT_W'(MAX_ATOMS)) begin
      mem_x[cnt_q[IDX_W-1:0]] <= sc_q[0];
      mem_y[cnt_q[IDX_W-1:0]] <= sc_q[1];
      mem_z[cnt_q[IDX_W-1:0]] <= sc_q[2];
    end
    if (cmd_i.rd) begin
      rd_q[0] <= mem_x[idx_q];
      rd_q[1] <= mem_y[idx_q];
      rd_q[2] <= mem_z[idx_q];
    end
  end

  // restoring divider, one quotient bit per cycle per axis
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_q <= {msum_q, 1'b0};
      for (int a = 0; a < 3; a++) begin
        logic [WSUM_W-1:0] mag;
        mag      = wsum_q[a][WSUM_W-1] ? -wsum_q[a] : wsum_q[a];
        neg_q[a] <= wsum_q[a][WSUM_W-1];
        num_q[a] <= {mag, 1'b0} + NUM_W'(msum_q);
        rem_q[a] <= '0;
        quo_q[a] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int a = 0; a < 3; a++) begin
        logic [REM_W-1:0] sh;
        sh       = {rem_q[a][REM_W-2:0], num_q[a][NUM_W-1]};
        num_q[a] <= {num_q[a][NUM_W-2:0], 1'b0};
        if (sh >= {1'b0, den_q}) begin
          rem_q[a] <= sh - {1'b0, den_q};
          quo_q[a] <= {quo_q[a][NUM_W-2:0], 1'b1};
        end else begin
          rem_q[a] <= sh;
          quo_q[a] <= {quo_q[a][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      idx_o        <= ATOM_IDX_W'(idx_q);
      mass_total_o <= msum_q;
      run_end_o    <= emit_last;
      zero_o       <= zero_c;
      for (int a = 0; a < 3; a++) begin
        logic signed [COORD_W:0] d;
        d = {rd_q[a][COORD_W-1], rd_q[a]} - {cen_c[a][COORD_W-1], cen_c[a]};
        cen_o[a] <= cen_c[a];
        if (d[COORD_W] != d[COORD_W-1])
          rel_o[a] <= d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
        else
          rel_o[a] <= d[COORD_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ATOMS))
    else $error("atom count past capacity");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (cnt_q == '0 && msum_q == '0 && idx_q == '0))
    else $error("molecule state not cleared");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (CNT_W'(idx_q) < cnt_q))
    else $error("emit index past stored atoms");
`endif

endmodule
